// ===== sv/pplc_pkg.sv =====
// shared widths, constants and types for the perspective point projection
package pplc_pkg;

  localparam int COORD_W = 32;             // q16.16 word
  localparam int COEF_REG_W = 64;          // two q16.16 coefficients per register
  localparam int SIZE_W = 14;              // screen size in pixels
  localparam int NUM_COEF_REGS = 6;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;
  localparam int PROD_FULL_W = 2 * COORD_W;  // exact q32.32 product
  localparam int FRAC_W = 16;
  localparam int ROW_W = 49;               // signed row sum, always fits
  localparam int MAG_W = ROW_W - 1;        // magnitude of a row sum
  localparam int HALF_SHIFT = 15;          // times 32768
  localparam int PROD_W = MAG_W + SIZE_W;  // magnitude times screen size
  localparam int Q_W = 33;                 // quotient bits kept before clamp
  localparam int LOW_W = Q_W - HALF_SHIFT; // product bits fed into the divider steps
  localparam int DIV_LAT = Q_W + 1;
  localparam int SUM_W = Q_W + 4;

  localparam logic signed [ROW_W-1:0] DEPTH_MIN = ROW_W'(66);
  localparam logic [SIZE_W-1:0] WIDTH_RESET = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_HORIZ_LO = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HORIZ_HI = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VERT_LO = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VERT_HI = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_LO = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_HI = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd7;

  typedef logic [NUM_COEF_REGS-1:0][COEF_REG_W-1:0] coef_regs_t;

  typedef struct packed {
    logic signed [ROW_W-1:0] h;
    logic signed [ROW_W-1:0] v;
    logic signed [ROW_W-1:0] d;
  } sums_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic vis;
  } res_t;

endpackage

// ===== sv/pplc_rows.sv =====
// view transform rows: products then floored sums
module pplc_rows import pplc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  coef_regs_t coefs,
  output logic sums_valid,
  output sums_t sums
);

  logic signed [COORD_W-1:0] coef [3][3];
  logic signed [COORD_W-1:0] offs [3];
  logic signed [COORD_W-1:0] pt [3];
  logic signed [PROD_FULL_W-1:0] prod [3][3];
  logic prod_valid;
  logic signed [ROW_W-1:0] row [3];

  always_comb begin
    pt[0] = point_x;
    pt[1] = point_y;
    pt[2] = point_z;
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = coefs[2*r][COORD_W-1:0];
      coef[r][1] = coefs[2*r][COEF_REG_W-1:COORD_W];
      coef[r][2] = coefs[2*r+1][COORD_W-1:0];
      offs[r] = coefs[2*r+1][COEF_REG_W-1:COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sums_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
      sums_valid <= prod_valid;
    end
  end

  // floor to q16.16 is the upper bits of the exact product, sign extended
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row[r] = ROW_W'(offs[r])
             + ROW_W'($signed(prod[r][0][PROD_FULL_W-1:FRAC_W]))
             + ROW_W'($signed(prod[r][1][PROD_FULL_W-1:FRAC_W]))
             + ROW_W'($signed(prod[r][2][PROD_FULL_W-1:FRAC_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= coef[r][c] * pt[c];
        end
      end
      sums.h <= row[0];
      sums.v <= row[1];
      sums.d <= row[2];
    end
  end

endmodule

// ===== sv/pplc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, clamped
module pplc_div import pplc_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic [PROD_W-1:0] num,
  input  logic [MAG_W-1:0] den,
  output logic [Q_W:0] quo
);

  logic [MAG_W-1:0] rem [0:Q_W];
  logic [MAG_W-1:0] dd [0:Q_W];
  logic [Q_W-1:0] nl [0:Q_W];
  logic [Q_W-1:0] qq [0:Q_W];
  logic ov [0:Q_W];
  logic [MAG_W-1:0] top_part;

  // numerator is num * 32768; its bits above the quotient range seed the remainder
  assign top_part = MAG_W'(num[PROD_W-1:LOW_W]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= top_part;
      ov[0] <= top_part >= den;
      nl[0] <= {num[LOW_W-1:0], {HALF_SHIFT{1'b0}}};
      qq[0] <= '0;
      dd[0] <= den;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [MAG_W:0] t;
    logic [MAG_W:0] diff;
    logic ge;
    assign t = {rem[k], nl[k][Q_W-1]};
    assign diff = t - {1'b0, dd[k]};
    assign ge = t >= {1'b0, dd[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
        qq[k+1] <= {qq[k][Q_W-2:0], ge};
        nl[k+1] <= {nl[k][Q_W-2:0], 1'b0};
        dd[k+1] <= dd[k];
        ov[k+1] <= ov[k];
      end
    end
  end

  assign quo = ov[Q_W] ? {1'b1, {Q_W{1'b0}}} : {1'b0, qq[Q_W]};

endmodule

// ===== sv/pplc_skid.sv =====
// output register with one skid entry
module pplc_skid import pplc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  input  res_t res,
  output logic en,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic skid_valid;
  res_t skid;
  logic take;

  assign take = out_valid && !out_stall;
  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (res_valid) begin
        if (!out_valid || take) begin
          out_res <= res;
          out_valid <= 1'b1;
        end else begin
          skid <= res;
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end else if (take) begin
      out_res <= skid;
      skid_valid <= 1'b0;
    end
  end

endmodule

// ===== sv/perspective_point_projection_core.sv =====
// top level of the perspective point projection pipeline
//
//  channel | words            | handshake
//  --------+------------------+-------------------------------------------
//  in      | point_x/y/z      | in_valid, in_stall
//  out     | screen_x/y, vis  | out_valid, out_stall
//  cfg     | cfg_index/data   | cfg_write, no wait, no read-back
//
// one word per cycle sustained while the skid entry is empty; 40 register
// stages lie between the edge that accepts the point and out_valid
// divider: one quotient bit per stage, 34 stages
// rst is synchronous; it clears valid bits and loads the default config
// a stall on out fills the skid entry; in_stall is that entry's full flag,
// and the whole pipeline holds while it is set
module perspective_point_projection_core import pplc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [COORD_W-1:0] screen_x,
  output logic signed [COORD_W-1:0] screen_y,
  output logic visible,
  input  logic cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COEF_REG_W-1:0] cfg_data
);

  typedef struct packed {
    logic valid;
    logic vis;
    logic hneg;
    logic vneg;
  } side_t;

  // configuration registers
  coef_regs_t coefs;
  logic [SIZE_W-1:0] scr_w;
  logic [SIZE_W-1:0] scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
      scr_w <= WIDTH_RESET;
      scr_h <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HORIZ_LO: coefs[0] <= cfg_data;
        REG_HORIZ_HI: coefs[1] <= cfg_data;
        REG_VERT_LO:  coefs[2] <= cfg_data;
        REG_VERT_HI:  coefs[3] <= cfg_data;
        REG_DEPTH_LO: coefs[4] <= cfg_data;
        REG_DEPTH_HI: coefs[5] <= cfg_data;
        REG_WIDTH:    scr_w <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT:   scr_h <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the skid entry is occupied
  logic en;
  assign in_stall = !en;

  // stages 1-2: row products and sums
  logic sums_valid;
  sums_t sums;

  pplc_rows u_rows (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(in_valid),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .coefs(coefs),
    .sums_valid(sums_valid),
    .sums(sums)
  );

  // stage 3: visibility test and magnitudes
  side_t side_c;
  logic [MAG_W-1:0] hm;
  logic [MAG_W-1:0] vm;
  logic [MAG_W-1:0] dm;
  logic [ROW_W-1:0] h_abs;
  logic [ROW_W-1:0] v_abs;

  assign h_abs = sums.h[ROW_W-1] ? -sums.h : sums.h;
  assign v_abs = sums.v[ROW_W-1] ? -sums.v : sums.v;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_c <= '0;
    end else if (en) begin
      side_c.valid <= sums_valid;
      side_c.vis <= sums.d > DEPTH_MIN;
      side_c.hneg <= sums.h[ROW_W-1];
      side_c.vneg <= sums.v[ROW_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hm <= h_abs[MAG_W-1:0];
      vm <= v_abs[MAG_W-1:0];
      dm <= sums.d[MAG_W-1:0];
    end
  end

  // stage 4: scale by screen size (the 32768 factor is folded into the divider)
  side_t side_d;
  logic [PROD_W-1:0] ph;
  logic [PROD_W-1:0] pv;
  logic [MAG_W-1:0] dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_d <= '0;
    end else if (en) begin
      side_d <= side_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph <= PROD_W'(hm) * PROD_W'(scr_w);
      pv <= PROD_W'(vm) * PROD_W'(scr_h);
      dd <= dm;
    end
  end

  // divider stages, horizontal and vertical side by side
  logic [Q_W:0] qx;
  logic [Q_W:0] qy;

  pplc_div u_div_x (.clk(clk), .en(en), .num(ph), .den(dd), .quo(qx));
  pplc_div u_div_y (.clk(clk), .en(en), .num(pv), .den(dd), .quo(qy));

  side_t side_line [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) side_line[i] <= '0;
    end else if (en) begin
      side_line[0] <= side_d;
      for (int i = 1; i < DIV_LAT; i++) side_line[i] <= side_line[i-1];
    end
  end

  // final stage: center offset, rounding half and saturation
  side_t side_f;
  logic signed [Q_W+1:0] sqx;
  logic signed [Q_W+1:0] sqy;
  logic signed [SUM_W-1:0] sx_full;
  logic signed [SUM_W-1:0] sy_full;
  logic res_valid;
  res_t res;
  res_t out_res;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(32768);
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) r = SAT_MAX[COORD_W-1:0];
    else if (v < SAT_MIN) r = SAT_MIN[COORD_W-1:0];
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  assign side_f = side_line[DIV_LAT-1];
  assign sqx = side_f.hneg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign sqy = side_f.vneg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign sx_full = $signed(SUM_W'({scr_w, {HALF_SHIFT{1'b0}}})) + SUM_W'(sqx) + HALF;
  assign sy_full = $signed(SUM_W'({scr_h, {HALF_SHIFT{1'b0}}})) - SUM_W'(sqy) - HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= side_f.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.vis <= side_f.vis;
      res.sx <= side_f.vis ? sat(sx_full) : '0;
      res.sy <= side_f.vis ? sat(sy_full) : '0;
    end
  end

  pplc_skid u_skid (
    .clk(clk),
    .rst(rst),
    .res_valid(res_valid && en),
    .res(res),
    .en(en),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res(out_res)
  );

  assign screen_x = out_res.sx;
  assign screen_y = out_res.sy;
  assign visible = out_res.vis;

endmodule

// ===== tb/projection_checker.sv =====
// checker for the perspective point projection: predicts every result and compares it
`timescale 1ns / 1ps
module projection_checker import pplc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic out_valid,
  input  logic out_stall,
  input  logic signed [COORD_W-1:0] screen_x,
  input  logic signed [COORD_W-1:0] screen_y,
  input  logic visible,
  input  logic cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COEF_REG_W-1:0] cfg_data,
  output int fail_count,
  output int pending_points
);

  logic [COEF_REG_W-1:0] view_rows [NUM_COEF_REGS];
  logic [SIZE_W-1:0] width_px, height_px;
  res_t projected_q [$];

  function automatic logic signed [63:0] widen(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // floored products plus offset, exact in 64 bits
  function automatic logic signed [63:0] row_total(logic [63:0] lo, logic [63:0] hi,
      logic signed [63:0] px, logic signed [63:0] py, logic signed [63:0] pz);
    logic signed [63:0] tx, ty, tz;
    tx = (widen(lo[31:0]) * px) >>> 16;
    ty = (widen(lo[63:32]) * py) >>> 16;
    tz = (widen(hi[31:0]) * pz) >>> 16;
    return tx + ty + tz + widen(hi[63:32]);
  endfunction

  // half the ratio times the screen size, truncated, magnitude clamped to 2^40
  function automatic logic signed [63:0] half_scaled(logic signed [63:0] num,
      logic [SIZE_W-1:0] size, logic signed [63:0] den);
    logic [63:0] mag;
    logic [127:0] prod, quo;
    mag = num[63] ? 64'(-num) : 64'(num);
    prod = {64'b0, mag} * {99'b0, size, 15'b0};
    quo = prod / {64'b0, den};
    if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
    return num[63] ? -$signed(quo[63:0]) : $signed(quo[63:0]);
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic res_t project_point(logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z);
    logic signed [63:0] hs, vs, ds, half_w, half_h;
    res_t r;
    hs = row_total(view_rows[0], view_rows[1], widen(x), widen(y), widen(z));
    vs = row_total(view_rows[2], view_rows[3], widen(x), widen(y), widen(z));
    ds = row_total(view_rows[4], view_rows[5], widen(x), widen(y), widen(z));
    r = '0;
    if (ds > 64'sd66) begin
      half_w = {35'b0, width_px, 15'b0};
      half_h = {35'b0, height_px, 15'b0};
      r.sx = clip32(half_w + half_scaled(hs, width_px, ds) + 64'sd32768);
      r.sy = clip32(half_h - (half_scaled(vs, height_px, ds) + 64'sd32768));
      r.vis = 1'b1;
    end
    return r;
  endfunction

  assign pending_points = projected_q.size();

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      foreach (view_rows[i]) view_rows[i] <= '0;
      width_px <= WIDTH_RESET;
      height_px <= HEIGHT_RESET;
      projected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH: width_px <= cfg_data[SIZE_W-1:0];
          REG_HEIGHT: height_px <= cfg_data[SIZE_W-1:0];
          default: view_rows[cfg_index] <= cfg_data;
        endcase
      end
      if (in_valid && !in_stall)
        projected_q.push_back(project_point(point_x, point_y, point_z));
      if (out_valid && !out_stall) begin
        if (projected_q.size() == 0) begin
          $error("result word with no point outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = projected_q.pop_front();
          if (screen_x !== want.sx || screen_y !== want.sy || visible !== want.vis)
            fail_count <= fail_count + 1;
          if (screen_x !== want.sx)
            $error("screen_x mismatch: expected %0d, got %0d", want.sx, screen_x);
          if (screen_y !== want.sy)
            $error("screen_y mismatch: expected %0d, got %0d", want.sy, screen_y);
          if (visible !== want.vis)
            $error("visible mismatch: expected %0d, got %0d", want.vis, visible);
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// stimulus and verdict for the perspective point projection core
`timescale 1ns / 1ps
module tb_top import pplc_pkg::*;;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 80;     // comfortably past the pipeline latency
  localparam int HOLD_CYCLES = 300;     // long receiver hold to back the pipe up

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, visible, cfg_write;
  logic signed [COORD_W-1:0] point_x, point_y, point_z, screen_x, screen_y;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [COEF_REG_W-1:0] cfg_data;
  int fail_count, pending_points;
  int cycle_count;
  bit burst_mode;      // sender and receiver run with no gaps
  bit hold_request;    // receiver does one long hold

  perspective_point_projection_core dut (.*);

  projection_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall before each word, stretches with none, one long hold
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = burst_mode ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      // wait until a word is taken at an edge with stall low
      do @(posedge clk); while (!out_valid);
    end
  end

  // offer one point; returns after the edge that takes it
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // registers change only once the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one write, then cfg_write is dropped so back to back writes never collide
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COEF_REG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // signed q16.16 value within plus or minus span
  function automatic logic [31:0] rand_q(int unsigned span);
    return 32'($signed($urandom_range(0, 2 * span)) - $signed(span));
  endfunction

  // coordinates: mostly moderate, some full range
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return rand_q(32'h0004_0000);
      default: return rand_q(32'h0100_0000);
    endcase
  endfunction

  task automatic random_view(bit wild);
    logic [31:0] dz, doff;
    if (wild) begin
      write_reg(REG_HORIZ_LO, {$urandom(), $urandom()});
      write_reg(REG_HORIZ_HI, {$urandom(), $urandom()});
      write_reg(REG_VERT_LO, {$urandom(), $urandom()});
      write_reg(REG_VERT_HI, {$urandom(), $urandom()});
      write_reg(REG_DEPTH_LO, {$urandom(), $urandom()});
      write_reg(REG_DEPTH_HI, {$urandom(), $urandom()});
    end else begin
      // a camera-like view: depth mostly driven by z with a forward offset
      dz = 32'($urandom_range(32'h0000_8000, 32'h0002_0000));
      doff = rand_q(32'h0010_0000);
      write_reg(REG_HORIZ_LO, {rand_q(32'h0000_4000), rand_q(32'h0002_0000)});
      write_reg(REG_HORIZ_HI, {rand_q(32'h0010_0000), rand_q(32'h0000_4000)});
      write_reg(REG_VERT_LO, {rand_q(32'h0002_0000), rand_q(32'h0000_4000)});
      write_reg(REG_VERT_HI, {rand_q(32'h0010_0000), rand_q(32'h0000_4000)});
      write_reg(REG_DEPTH_LO, {rand_q(32'h0000_2000), rand_q(32'h0000_2000)});
      write_reg(REG_DEPTH_HI, {doff, dz});
    end
    write_reg(REG_WIDTH, 64'($urandom_range(0, 16383)));
    write_reg(REG_HEIGHT, 64'($urandom_range(0, 16383)));
  endtask

  initial begin
    int items;
    rst = 1'b1;
    in_valid = 1'b0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_mode = 1'b0;
    hold_request = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset view: zero depth row, nothing visible
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);

    // identity view at the default screen size
    wait_idle();
    write_reg(REG_HORIZ_LO, {32'h0, 32'h0001_0000});
    write_reg(REG_VERT_LO, {32'h0001_0000, 32'h0});
    write_reg(REG_DEPTH_HI, {32'h0, 32'h0001_0000});
    send_point(32'h0, 32'h0, 32'd66);              // depth right at the threshold
    send_point(32'h0, 32'h0, 32'd67);              // just past the threshold
    send_point(32'h0001_0000, 32'h0001_0000, 32'd67);
    send_point(32'h0001_0000, 32'hffff_0000, 32'hffff_0000); // behind the camera
    send_point(32'h0, 32'h0, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'd100);       // saturates both ways
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'd100);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h0002_0000, 32'hfffe_0000, 32'h0004_0000);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'h0001_0000);

    // zero screen size, then the largest codes
    wait_idle();
    write_reg(REG_WIDTH, 64'd0);
    write_reg(REG_HEIGHT, 64'd0);
    send_point(32'h0003_0000, 32'hfffd_0000, 32'h0001_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'd70);
    wait_idle();
    write_reg(REG_WIDTH, 64'h3fff);
    write_reg(REG_HEIGHT, 64'hffff_ffff_ffff_ffff);
    send_point(32'h0003_0000, 32'hfffd_0000, 32'h0001_0000);
    send_point(32'h0, 32'h0, 32'h7fff_ffff);
    send_point(32'h0000_0100, 32'hffff_ff00, 32'd67);
    wait_idle();
    write_reg(REG_WIDTH, 64'd8192);
    write_reg(REG_HEIGHT, 64'd1);
    send_point(32'h0001_8000, 32'hffff_8000, 32'h0002_0000);

    // all-ones and most negative coefficients
    wait_idle();
    write_reg(REG_HORIZ_LO, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_HORIZ_HI, 64'h8000_0000_8000_0000);
    write_reg(REG_VERT_LO, 64'h7fff_ffff_7fff_ffff);
    write_reg(REG_VERT_HI, 64'h8000_0000_7fff_ffff);
    write_reg(REG_DEPTH_LO, 64'h0);
    write_reg(REG_DEPTH_HI, 64'h7fff_ffff_0000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h0, 32'hffff_ffff, 32'h1);

    // random phases: mostly camera-like views, some wild ones
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      random_view(phase % 4 == 3);
      burst_mode = (phase == 2 || phase == 6);
      if (phase == 6) hold_request = 1'b1;  // sender keeps offering during the hold
      items = 120;
      for (int n = 0; n < items; n++)
        send_point(rand_coord(), rand_coord(), rand_coord());
      burst_mode = 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
